// ===== sv/des_rkg_pkg.sv =====
`default_nettype none

package des_rkg_pkg;

   localparam int KEY_BITS   = 64;
   localparam int HALF_BITS  = 28;
   localparam int CD_BITS    = 56;
   localparam int SUBKEY_BITS = 48;
   localparam int ROUND_BITS = 4;

   localparam logic [ROUND_BITS-1:0] ROUND_FIRST = 4'd0;
   localparam logic [ROUND_BITS-1:0] ROUND_LAST  = 4'd15;

   typedef logic [HALF_BITS-1:0]   half_type;
   typedef logic [SUBKEY_BITS-1:0] subkey_type;
   typedef logic [ROUND_BITS-1:0]  round_type;

   typedef struct packed {
      subkey_type subkey;
      round_type  round_index;
      logic       last;
   } beat_type;

   // bit positions are counted from 1 at the msb
   localparam logic [6:0] PC1_TABLE [CD_BITS] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
      7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
      7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
      7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
      7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
      7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
      7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   localparam logic [5:0] PC2_TABLE [SUBKEY_BITS] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
      6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
      6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
      6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
      6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
      6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
      6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
   };

   function automatic logic [CD_BITS-1:0] choice_one(input logic [KEY_BITS-1:0] key);
      logic [CD_BITS-1:0] cd;
      logic [5:0]         idx;
      cd  = '0;
      idx = '0;
      for (int i = 0; i < CD_BITS; i++) begin
         idx = 6'(7'd64 - PC1_TABLE[i]);
         cd[CD_BITS-1-i] = key[idx];
      end
      return cd;
   endfunction

   function automatic subkey_type choice_two(input logic [CD_BITS-1:0] cd);
      subkey_type sk;
      logic [5:0] idx;
      sk  = '0;
      idx = '0;
      for (int i = 0; i < SUBKEY_BITS; i++) begin
         idx = 6'd56 - PC2_TABLE[i];
         sk[SUBKEY_BITS-1-i] = cd[idx];
      end
      return sk;
   endfunction

   function automatic logic single_shift(input round_type r);
      return (r == 4'd0) || (r == 4'd1) || (r == 4'd8) || (r == 4'd15);
   endfunction

   function automatic half_type rotate_half(input half_type h, input logic one_place);
      if (one_place) begin
         return {h[HALF_BITS-2:0], h[HALF_BITS-1]};
      end
      return {h[HALF_BITS-3:0], h[HALF_BITS-1:HALF_BITS-2]};
   endfunction

endpackage

`default_nettype wire

// ===== sv/des_rkg_schedule.sv =====
`default_nettype none

module des_rkg_schedule (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [63:0]           req_key,
   output logic                       req_stall,
   input  wire logic                  take,
   output logic                       beat_valid,
   output des_rkg_pkg::beat_type      beat
);
   import des_rkg_pkg::*;

   half_type  half_c_ff, half_c_in;
   half_type  half_d_ff, half_d_in;
   round_type round_ff, round_in;
   logic      busy_ff, busy_in;

   logic                 advance;
   logic                 accept;
   logic                 one_place;
   half_type             rot_c;
   half_type             rot_d;
   logic [CD_BITS-1:0]   cd_key;

   always_comb begin
      one_place = single_shift(round_ff);
      rot_c     = rotate_half(half_c_ff, one_place);
      rot_d     = rotate_half(half_d_ff, one_place);
      advance   = busy_ff && take;
      req_stall = busy_ff && !(advance && (round_ff == ROUND_LAST));
      accept    = req_valid && !req_stall;
      cd_key    = choice_one(req_key);

      beat_valid       = busy_ff;
      beat.subkey      = choice_two({rot_c, rot_d});
      beat.round_index = round_ff;
      beat.last        = (round_ff == ROUND_LAST);

      half_c_in = half_c_ff;
      half_d_in = half_d_ff;
      round_in  = round_ff;
      busy_in   = busy_ff;
      if (advance) begin
         half_c_in = rot_c;
         half_d_in = rot_d;
         round_in  = round_ff + 4'd1;
         busy_in   = (round_ff != ROUND_LAST);
      end
      if (accept) begin
         half_c_in = cd_key[CD_BITS-1:HALF_BITS];
         half_d_in = cd_key[HALF_BITS-1:0];
         round_in  = ROUND_FIRST;
         busy_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_c_ff <= '0;
         half_d_ff <= '0;
         round_ff  <= ROUND_FIRST;
         busy_ff   <= 1'b0;
      end else begin
         half_c_ff <= half_c_in;
         half_d_ff <= half_d_in;
         round_ff  <= round_in;
         busy_ff   <= busy_in;
      end
   end

   // a new key always starts at the first round
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && (round_ff == ROUND_FIRST)))
      else $error("schedule did not restart on new key");

   // a blocked round holds its position
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !take) |=> (busy_ff && $stable(round_ff) && $stable(half_c_ff)))
      else $error("round moved while output blocked");

   // the schedule only ends after the last round goes out
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !accept && !(advance && (round_ff == ROUND_LAST))) |=> busy_ff)
      else $error("schedule ended early");

   // no new key is taken mid schedule
   assert property (@(posedge clock) disable iff (reset)
      (accept && busy_ff) |-> (advance && (round_ff == ROUND_LAST)))
      else $error("key accepted mid schedule");

endmodule

`default_nettype wire

// ===== sv/des_rkg_out_reg.sv =====
`default_nettype none

module des_rkg_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  beat_valid,
   input  wire des_rkg_pkg::beat_type beat,
   output logic                       take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [47:0]                rsp_subkey,
   output logic [3:0]                 rsp_round_index,
   output logic                       rsp_last
);
   import des_rkg_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff;

   always_comb begin
      take     = !valid_ff || !rsp_stall;
      valid_in = valid_ff;
      if (take) begin
         valid_in = beat_valid;
      end
      rsp_valid       = valid_ff;
      rsp_subkey      = beat_ff.subkey;
      rsp_round_index = beat_ff.round_index;
      rsp_last        = beat_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && beat_valid) begin
         beat_ff <= beat;
      end
   end

endmodule

`default_nettype wire

// ===== sv/des_round_key_generator_core.sv =====
`default_nettype none

// DES key schedule. Each key transaction on req_ yields sixteen rsp_ transactions, the
// PC-2 subkeys of rounds 0 to 15 in order, with rsp_last set on round 15. One subkey
// leaves per cycle while rsp_stall is low, a rate set by the single rotate and PC-2 stage
// that produces one round per cycle; the next key is taken in the cycle the round 15 subkey
// moves into the output register, so keys stream back to back with no gap. An accepted key
// is loaded into the schedule register, and its round 0 subkey then passes through the output
// register to rsp_. Parity bits of the key are ignored and every key pattern is accepted.

module des_round_key_generator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_key,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [47:0]      rsp_subkey,
   output logic [3:0]       rsp_round_index,
   output logic             rsp_last
);
   import des_rkg_pkg::*;

   logic     take;
   logic     beat_valid;
   beat_type beat;

   des_rkg_schedule u_schedule (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_key    (req_key),
      .req_stall  (req_stall),
      .take       (take),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   des_rkg_out_reg u_out_reg (
      .clock           (clock),
      .reset           (reset),
      .beat_valid      (beat_valid),
      .beat            (beat),
      .take            (take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_subkey      (rsp_subkey),
      .rsp_round_index (rsp_round_index),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sim/tb_des_round_key_generator_core.sv =====
`default_nettype none

module tb_des_round_key_generator_core;
   import des_rkg_pkg::*;

   localparam int CLOCK_PERIOD      = 10;
   localparam int RESET_CYCLES      = 9;
   localparam int KEYS_PER_PHASE    = 78;
   localparam int TAIL_CYCLES       = 20;
   localparam int QUIET_LIMIT       = 4000;
   localparam int PHASES            = 4;
   localparam logic [63:0] PARITY_BITS = 64'h0101010101010101;

   // idle and stall odds per random phase, in percent
   localparam int SEND_IDLE [PHASES] = '{0, 75, 0, 38};
   localparam int RECV_STALL [PHASES] = '{0, 0, 75, 38};

   localparam int PERM_ONE [CD_BITS] = '{
      57, 49, 41, 33, 25, 17,  9,
       1, 58, 50, 42, 34, 26, 18,
      10,  2, 59, 51, 43, 35, 27,
      19, 11,  3, 60, 52, 44, 36,
      63, 55, 47, 39, 31, 23, 15,
       7, 62, 54, 46, 38, 30, 22,
      14,  6, 61, 53, 45, 37, 29,
      21, 13,  5, 28, 20, 12,  4
   };

   localparam int PERM_TWO [SUBKEY_BITS] = '{
      14, 17, 11, 24,  1,  5,
       3, 28, 15,  6, 21, 10,
      23, 19, 12,  4, 26,  8,
      16,  7, 27, 20, 13,  2,
      41, 52, 31, 37, 47, 55,
      30, 40, 51, 45, 33, 48,
      44, 49, 39, 56, 34, 53,
      46, 42, 50, 36, 29, 32
   };

   // weak, semi-weak, parity-only, textbook and edge patterns
   localparam logic [63:0] DIRECTED_KEYS [20] = '{
      64'h0000000000000000, 64'hffffffffffffffff, 64'h0101010101010101,
      64'hfefefefefefefefe, 64'h1f1f1f1f0e0e0e0e, 64'he0e0e0e0f1f1f1f1,
      64'h01fe01fe01fe01fe, 64'h133457799bbcdff1, 64'h0123456789abcdef,
      64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 64'h8000000000000000,
      64'h0000000000000001, 64'h0000000000000080, 64'h00000000ffffffff,
      64'hffffffff00000000, 64'hf0f0f0f0f0f0f0f0, 64'h0f0f0f0f0f0f0f0f,
      64'h7f7f7f7f7f7f7f7f, 64'hfefefefefefefeff
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [47:0] rsp_subkey;
   logic [3:0]  rsp_round_index;
   logic        rsp_last;

   logic [63:0] pending_keys [$];
   beat_type    expected_subkeys [$];
   int          keys_offered = 0;
   int          keys_taken = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          failures = 0;
   int          quiet_cycles = 0;

   des_round_key_generator_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_subkey      (rsp_subkey),
      .rsp_round_index (rsp_round_index),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // queues the sixteen subkeys of one key in round order
   function automatic void schedule_subkeys(input logic [63:0] key);
      logic [CD_BITS-1:0] cd;
      half_type           c;
      half_type           d;
      beat_type           beat;
      int                 amount;
      for (int i = 0; i < CD_BITS; i++) begin
         cd[CD_BITS-1-i] = key[64-PERM_ONE[i]];
      end
      c = cd[CD_BITS-1:HALF_BITS];
      d = cd[HALF_BITS-1:0];
      for (int r = 0; r < 16; r++) begin
         amount = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
         c = (c << amount) | (c >> (HALF_BITS - amount));
         d = (d << amount) | (d >> (HALF_BITS - amount));
         cd = {c, d};
         for (int i = 0; i < SUBKEY_BITS; i++) begin
            beat.subkey[SUBKEY_BITS-1-i] = cd[CD_BITS-PERM_TWO[i]];
         end
         beat.round_index = round_type'(r);
         beat.last = (round_type'(r) == ROUND_LAST);
         expected_subkeys.push_back(beat);
      end
   endfunction

   task automatic drain_phase();
      do @(negedge clock);
      while (pending_keys.size() != 0 || keys_taken != keys_offered ||
             expected_subkeys.size() != 0);
   endtask

   always @(negedge clock) begin : drive_keys
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && !(req_valid && keys_taken != keys_offered)) begin
         if (pending_keys.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_key <= pending_keys.pop_front();
            req_valid <= 1'b1;
            keys_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_subkeys
      beat_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_subkeys.size() == 0) begin
               $error("unexpected rsp transaction: subkey %h round_index %0d last %0b",
                      rsp_subkey, rsp_round_index, rsp_last);
               failures++;
            end else begin
               want = expected_subkeys.pop_front();
               if (rsp_subkey !== want.subkey) begin
                  $error("subkey: expected %h, actual %h", want.subkey, rsp_subkey);
                  failures++;
               end
               if (rsp_round_index !== want.round_index) begin
                  $error("round_index: expected %0d, actual %0d",
                         want.round_index, rsp_round_index);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            schedule_subkeys(req_key);
            keys_taken <= keys_taken + 1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [63:0] key;
      logic [63:0] prior;
      int          pick;
      prior = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_KEYS[i]) pending_keys.push_back(DIRECTED_KEYS[i]);
      drain_phase();

      for (int p = 0; p < PHASES; p++) begin
         idle_pct = SEND_IDLE[p];
         stall_pct = RECV_STALL[p];
         for (int i = 0; i < KEYS_PER_PHASE; i++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
               // same key with only the parity bits changed
               key = prior ^ ({$urandom, $urandom} & PARITY_BITS);
            end else if (pick == 1) begin
               key = prior;
            end else begin
               key = {$urandom, $urandom};
            end
            pending_keys.push_back(key);
            prior = key;
         end
         drain_phase();
      end

      stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/des_rkg_pkg.sv
sv/des_rkg_schedule.sv
sv/des_rkg_out_reg.sv
sv/des_round_key_generator_core.sv
sim/tb_des_round_key_generator_core.sv
